>>> sv/ntal_pkg.sv
// ----------------------------------------------------------------------------
// ntal_pkg
// Types and codes shared by the name table cells and the top level.
// ----------------------------------------------------------------------------
package ntal_pkg;

  localparam int KEY_W = 64;

  localparam logic [1:0] CMD_LIST = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DELETED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_LISTED   = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] name_key;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [KEY_W-1:0] entry_key;
    logic             last;
  } out_item_t;

  // operation broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ADD,
    CELL_CMP,
    CELL_DEL,
    CELL_ROT
  } cell_mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL,
    S_LIST
  } state_t;

endpackage

>>> sv/name_table_add_delete_list_unit.sv
// ----------------------------------------------------------------------------
// name_table_add_delete_list_unit
// Ordered table of name keys kept in a row of cells: add, delete, list.
// ----------------------------------------------------------------------------
// Usage: drive in_item and raise start; the item is taken on a rising edge
// with start high and busy low. Results come out on out_item with a one
// cycle out_valid strobe; the receiver must take them as they come.
// Add: one result, strobed in the cycle right after the item is taken; the
// key is written straight into the cell at the fill count. Adds can follow
// each other in every cycle.
// Delete: when the item is taken every cell compares its key; then in S_DEL a
// hit chain along the row marks the first match and every cell from there
// on takes its right neighbor's key. The one result is registered at the end
// of S_DEL, and the next item can be taken once the unit is idle again.
// List: one result per stored entry, one per cycle, each taken from the head
// cell in S_LIST; the row rotates one place a cycle and is left in order
// after the last entry; the next item can be taken once the unit is idle.
// An empty table gives a single empty result. cmd 3 is dropped.
// busy stays high while a delete or list is under way.
// Reset clears the fill count and control; cell contents are not cleared.
// ----------------------------------------------------------------------------
module name_table_add_delete_list_unit #(
  parameter int CAPACITY  = 16,
  parameter int NAME_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ntal_pkg::in_item_t in_item,
  output logic               out_valid,
  output ntal_pkg::out_item_t out_item
);
  import ntal_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  state_t     state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] lcnt_r, lcnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;
  cell_mode_t mode;

  logic [NAME_BITS-1:0] new_key;
  logic [NAME_BITS-1:0] cell_key [CAPACITY];
  logic                 hit [CAPACITY+1];
  logic                 accept;

  assign new_key = in_item.name_key[NAME_BITS-1:0];
  assign hit[0]  = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [NAME_BITS-1:0] nxt_key;
    if (i == CAPACITY - 1) begin : g_end
      assign nxt_key = cell_key[i];
    end else begin : g_mid
      assign nxt_key = cell_key[i+1];
    end
    ntal_cell #(
      .IDX (i),
      .CW  (CW),
      .NB  (NAME_BITS)
    ) u_cell (
      .clk      (clk),
      .mode     (mode),
      .count    (count_r),
      .new_key  (new_key),
      .next_key (nxt_key),
      .head_key (cell_key[0]),
      .hit_in   (hit[i]),
      .hit_out  (hit[i+1]),
      .key_out  (cell_key[i])
    );
  end

  assign busy      = state_r != S_IDLE;
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lcnt_r      <= lcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lcnt_nxt      = lcnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mode          = CELL_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_item_nxt.entry_key = '0;
          out_item_nxt.last      = 1'b1;
          priority if (in_item.cmd == CMD_LIST) begin
            if (count_r == '0) begin
              out_valid_nxt         = 1'b1;
              out_item_nxt.status   = ST_EMPTY;
            end else begin
              state_nxt = S_LIST;
              lcnt_nxt  = '0;
            end
          end else if (in_item.cmd == CMD_ADD) begin
            out_valid_nxt = 1'b1;
            if (count_r < CW'(CAPACITY)) begin
              mode                = CELL_ADD;
              count_nxt           = count_r + CW'(1);
              out_item_nxt.status = ST_ADDED;
            end else begin
              out_item_nxt.status = ST_FULL;
            end
          end else if (in_item.cmd == CMD_DEL) begin
            mode      = CELL_CMP;
            state_nxt = S_DEL;
          end else begin
            // unused command: dropped
          end
        end
      end
      S_DEL: begin
        mode          = CELL_DEL;
        out_valid_nxt = 1'b1;
        out_item_nxt.entry_key = '0;
        out_item_nxt.last      = 1'b1;
        if (hit[CAPACITY]) begin
          count_nxt           = count_r - CW'(1);
          out_item_nxt.status = ST_DELETED;
        end else begin
          out_item_nxt.status = ST_NOTFOUND;
        end
        state_nxt = S_IDLE;
      end
      S_LIST: begin
        mode                   = CELL_ROT;
        out_valid_nxt          = 1'b1;
        out_item_nxt.status    = ST_LISTED;
        out_item_nxt.entry_key = KEY_W'(cell_key[0]);
        out_item_nxt.last      = (lcnt_r + CW'(1)) == count_r;
        lcnt_nxt               = lcnt_r + CW'(1);
        if ((lcnt_r + CW'(1)) == count_r) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status == ST_ADDED |-> count_r == $past(count_r) + CW'(1))
    else $error("added result without count increment");

  a_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status == ST_DELETED |-> count_r == $past(count_r) - CW'(1))
    else $error("deleted result without count decrement");

  a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.last && out_item_r.status == ST_LISTED |-> state_r == S_IDLE)
    else $error("list ended but unit still busy");

endmodule

>>> sv/ntal_cell.sv
// ----------------------------------------------------------------------------
// ntal_cell
// One table slot: holds a key, takes a new key on an add, compares it, takes
// a key from its right neighbor on a delete shift or a list rotation (the tail takes the head).
// ----------------------------------------------------------------------------
module ntal_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5,
  parameter int NB  = 64
) (
  input  logic                clk,
  input  ntal_pkg::cell_mode_t mode,
  input  logic [CW-1:0]       count,
  input  logic [NB-1:0]       new_key,
  input  logic [NB-1:0]       next_key,
  input  logic [NB-1:0]       head_key,
  input  logic                hit_in,
  output logic                hit_out,
  output logic [NB-1:0]       key_out
);
  import ntal_pkg::*;

  logic [NB-1:0] key_r;
  logic          match_r;
  logic          occupied;
  logic          is_tail;
  logic          is_slot;

  assign occupied = CW'(IDX) < count;
  assign is_tail  = CW'(IDX + 1) == count;
  assign is_slot  = CW'(IDX) == count;
  // first match anywhere at or left of this cell
  assign hit_out  = hit_in | match_r;
  assign key_out  = key_r;

  always_ff @(posedge clk) begin
    if (mode == CELL_CMP) begin
      match_r <= occupied && (key_r == new_key);
    end
  end

  always_ff @(posedge clk) begin
    unique case (mode)
      CELL_ADD: begin
        if (is_slot) key_r <= new_key;
      end
      CELL_DEL: begin
        if (hit_out) key_r <= next_key;
      end
      CELL_ROT: begin
        // tail takes the head so the row returns to order after a full rotation
        if (is_tail) key_r <= head_key;
        else if (occupied) key_r <= next_key;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives list, add, delete and unused-command items into the name table and checks each
// result against a local model of the ordered key table and its fill count.
// ----------------------------------------------------------------------------
module testbench;
  import ntal_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int NAME_BITS  = 64;
  localparam int QUIET_MAX  = 2000;
  localparam int TAIL_WAIT  = 20;
  localparam int RAND_ITEMS = 75;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic             typed;
    logic [2:0]       status;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // typed expectation riding along with the item in the directed part
  logic       row_typed;
  logic [2:0] row_status;

  logic [KEY_W-1:0] dir_keys [CAPACITY];
  int               dir_count;
  out_item_t        awaited_replies [$];
  int               mismatch_count;
  int               quiet_cycles;
  dir_row_t         script [$];
  out_item_t        want;

  name_table_add_delete_list_unit #(
    .CAPACITY  (CAPACITY),
    .NAME_BITS (NAME_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  function automatic out_item_t reply(input logic [2:0] status,
                                      input logic [KEY_W-1:0] key,
                                      input logic last);
    reply.status    = status;
    reply.entry_key = key;
    reply.last      = last;
  endfunction

  // apply one item to the local table and queue the replies it causes
  task automatic predict_replies(input in_item_t it);
    int hit;
    hit = -1;
    case (it.cmd)
      CMD_LIST: begin
        if (dir_count == 0) begin
          awaited_replies.push_back(reply(ST_EMPTY, '0, 1'b1));
        end else begin
          for (int i = 0; i < dir_count; i++)
            awaited_replies.push_back(reply(ST_LISTED, dir_keys[i], i == dir_count - 1));
        end
      end
      CMD_ADD: begin
        if (dir_count < CAPACITY) begin
          dir_keys[dir_count] = it.name_key;
          dir_count++;
          awaited_replies.push_back(reply(ST_ADDED, '0, 1'b1));
        end else begin
          awaited_replies.push_back(reply(ST_FULL, '0, 1'b1));
        end
      end
      CMD_DEL: begin
        for (int i = 0; i < dir_count; i++)
          if (hit < 0 && dir_keys[i] == it.name_key) hit = i;
        if (hit >= 0) begin
          for (int j = hit; j + 1 < dir_count; j++) dir_keys[j] = dir_keys[j + 1];
          dir_count--;
          awaited_replies.push_back(reply(ST_DELETED, '0, 1'b1));
        end else begin
          awaited_replies.push_back(reply(ST_NOTFOUND, '0, 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag_reply(input string what, input out_item_t exp_r, input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected status %0d key %h last %b, got status %0d key %h last %b",
               $realtime, what, exp_r.status, exp_r.entry_key, exp_r.last,
               got.status, got.entry_key, got.last);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_replies(in_item);
        if (row_typed && awaited_replies.size() > 0)
          awaited_replies[awaited_replies.size() - 1] = reply(row_status, '0, 1'b1);
      end
      if (out_valid) begin
        if (awaited_replies.size() == 0) begin
          flag_reply("unexpected result", '0, out_item);
        end else begin
          want = awaited_replies.pop_front();
          if (out_item.status !== want.status || out_item.entry_key !== want.entry_key ||
              out_item.last !== want.last)
            flag_reply("result mismatch", want, out_item);
        end
      end
    end
  end

  // watchdog: cycles with neither an item nor a result taken
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_row(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                         input logic typed, input logic [2:0] status);
    script.push_back({cmd, key, typed, status});
  endtask

  // hold the item until the block takes it; start stays high on return
  task automatic offer(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                       input logic typed, input logic [2:0] status);
    in_item    <= {cmd, key};
    row_typed  <= typed;
    row_status <= status;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [KEY_W-1:0] key_pool [6];
    logic [KEY_W-1:0] rkey;
    logic [1:0]       rcmd;
    int               sent;
    int               burst_left;
    int               pick;
    bit               filling;
    bit               paused;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    row_typed      = 1'b0;
    row_status     = ST_ADDED;
    dir_count      = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    foreach (dir_keys[i]) dir_keys[i] = '0;

    add_row(CMD_LIST, '1, 1'b1, ST_EMPTY);
    add_row(CMD_DEL, '0, 1'b1, ST_NOTFOUND);
    add_row(CMD_ADD, '0, 1'b1, ST_ADDED);
    add_row(CMD_ADD, '1, 1'b1, ST_ADDED);
    add_row(CMD_LIST, '0, 1'b0, ST_LISTED);
    // fill to capacity with walking ones and a second zero key
    for (int k = 0; k < 14; k++)
      add_row(CMD_ADD, (k == 7) ? '0 : (64'h1 << (k * 4 + 1)), 1'b1, ST_ADDED);
    add_row(CMD_ADD, 64'h8000_0000_0000_0000, 1'b1, ST_FULL);
    add_row(CMD_LIST, '0, 1'b0, ST_LISTED);
    add_row(CMD_DEL, '0, 1'b1, ST_DELETED);
    add_row(CMD_DEL, 64'h3, 1'b1, ST_NOTFOUND);
    add_row(CMD_UNUSED, '1, 1'b0, ST_ADDED);
    add_row(CMD_LIST, '0, 1'b0, ST_LISTED);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r]) begin
      offer(script[r].cmd, script[r].key, script[r].typed, script[r].status);
      hold_off($urandom_range(0, 2));
    end
    drain();

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < 6; k++) key_pool[k] = {$urandom, $urandom};
    sent       = 0;
    burst_left = $urandom_range(1, 10);
    filling    = 1'b1;
    paused     = 1'b0;
    while (sent < RAND_ITEMS) begin
      // swing between filling and draining so both full and empty come up
      if (dir_count >= CAPACITY) filling = 1'b0;
      else if (dir_count == 0) filling = 1'b1;
      if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(2, 5)] = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      rkey = key_pool[$urandom_range(0, 5)];
      if (filling) begin
        if (pick < 60) rcmd = CMD_ADD;
        else if (pick < 75) rcmd = CMD_DEL;
        else if (pick < 90) rcmd = CMD_LIST;
        else if (pick < 96) begin
          rcmd = CMD_ADD;
          rkey = {$urandom, $urandom};
        end else rcmd = CMD_UNUSED;
      end else begin
        if (pick < 15) rcmd = CMD_ADD;
        else if (pick < 70) rcmd = CMD_DEL;
        else if (pick < 80) begin
          rcmd = CMD_DEL;
          rkey = {$urandom, $urandom};
        end else if (pick < 95) rcmd = CMD_LIST;
        else rcmd = CMD_UNUSED;
      end
      if (rcmd == CMD_UNUSED) rkey = {$urandom, $urandom};
      offer(rcmd, rkey, 1'b0, ST_ADDED);
      if (rcmd != CMD_UNUSED) sent++;
      if (!paused && sent >= RAND_ITEMS / 2) begin
        paused = 1'b1;
        drain();
      end
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0 && awaited_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
